### src/fss_pkg.sv
// fss_pkg: types and constants shared by the frame signature statistics block.
// Holds field widths, FNV-1a constants, divider sizing, controller states and
// the command and status structs between controller and datapath.
package fss_pkg;

	// field widths
	localparam int unsigned CFG_W   = 24;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned HASH_W  = 32;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned MEAN_W  = 18;

	// FNV-1a 32-bit constants
	localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

	// mean in thousandths: sum * 1000 needs ten more bits than the sum
	localparam int unsigned MILLI_W = 10;
	localparam logic [MILLI_W-1:0] MILLI = 10'd1000;
	localparam int unsigned DVD_W = SUM_W + MILLI_W;
	localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

	localparam logic [BYTE_W-1:0] BYTE_TOP = 8'd255;
	localparam logic [CFG_W-1:0]  FRAME_LENGTH_RST = 24'd1;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_LAUNCH,
		ST_DIVIDE,
		ST_HOLD
	} fss_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;       // byte transfer this cycle
		logic div_start;  // load divider from the frame snapshot
		logic load_out;   // move finished result into the output register
	} fss_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_byte;   // next byte closes the frame
		logic frame_empty; // no byte of the current frame taken yet
		logic div_busy;
		logic div_done;
	} fss_stat_t;

endpackage

### src/fss_if.sv
// fss_if: valid/ready channel interfaces for the byte input and the result output.
// Depends on fss_pkg for field widths.
interface fss_in_if;
	logic                        valid;
	logic                        ready;
	logic [fss_pkg::BYTE_W-1:0]  pixel_byte;

	modport source (output valid, output pixel_byte, input ready);
	modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface fss_out_if;
	logic                        valid;
	logic                        ready;
	logic [fss_pkg::HASH_W-1:0]  frame_hash;
	logic [fss_pkg::SUM_W-1:0]   byte_total;
	logic [fss_pkg::BYTE_W-1:0]  min_byte;
	logic [fss_pkg::BYTE_W-1:0]  max_byte;
	logic [fss_pkg::BYTE_W-1:0]  head_byte;
	logic [fss_pkg::BYTE_W-1:0]  center_byte;
	logic [fss_pkg::BYTE_W-1:0]  tail_byte;
	logic [fss_pkg::MEAN_W-1:0]  avg_thousandths;

	modport source (output valid, output frame_hash, output byte_total, output min_byte,
		output max_byte, output head_byte, output center_byte, output tail_byte,
		output avg_thousandths, input ready);
	modport sink   (input valid, input frame_hash, input byte_total, input min_byte,
		input max_byte, input head_byte, input center_byte, input tail_byte,
		input avg_thousandths, output ready);
endinterface

### src/fss_div.sv
// fss_div: restoring radix-2 divider, one quotient bit per cycle.
// Depends on fss_pkg for the dividend width and step counter width.
module fss_div #(
	parameter int unsigned DIVISOR_W = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fss_pkg::DVD_W-1:0]   dividend,
	input  logic [DIVISOR_W-1:0]        divisor,
	output logic [fss_pkg::DVD_W-1:0]   quotient,
	output logic                        busy,
	output logic                        done
);

	localparam int unsigned DW = fss_pkg::DVD_W;

	// dvd_q shifts out dividend bits at the top and collects quotient bits at the bottom
	logic [DW-1:0]                     dvd_q;
	logic [DIVISOR_W-1:0]              rem_q;
	logic [DIVISOR_W-1:0]              dvs_q;
	logic [fss_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                              busy_q;
	logic                              done_q;

	logic [DIVISOR_W:0] rem_sh;
	logic [DIVISOR_W:0] diff;
	logic               ge;

	// one trial subtraction
	always_comb begin
		rem_sh = {rem_q, dvd_q[DW-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = ~diff[DIVISOR_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= fss_pkg::DIV_CNT_W'(DW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - fss_pkg::DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

### src/fss_dp.sv
// fss_dp: datapath with the length register, running frame statistics, frame
// snapshot, mean divider and output register. Depends on fss_pkg and fss_div.
module fss_dp #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fss_pkg::CFG_W-1:0]     cfg_wdata,
	input  fss_pkg::fss_cmd_t             cmd,
	output fss_pkg::fss_stat_t            st,
	input  logic [fss_pkg::BYTE_W-1:0]    pixel_byte,
	output logic [fss_pkg::HASH_W-1:0]    frame_hash,
	output logic [fss_pkg::SUM_W-1:0]     byte_total,
	output logic [fss_pkg::BYTE_W-1:0]    min_byte,
	output logic [fss_pkg::BYTE_W-1:0]    max_byte,
	output logic [fss_pkg::BYTE_W-1:0]    head_byte,
	output logic [fss_pkg::BYTE_W-1:0]    center_byte,
	output logic [fss_pkg::BYTE_W-1:0]    tail_byte,
	output logic [fss_pkg::MEAN_W-1:0]    avg_thousandths
);

	localparam int unsigned LB = LENGTH_BITS;
	localparam int unsigned BW = fss_pkg::BYTE_W;

	logic [fss_pkg::CFG_W-1:0]  frame_length_q;

	// running state
	logic [fss_pkg::HASH_W-1:0] hash_q;
	logic [fss_pkg::SUM_W-1:0]  sum_q;
	logic [BW-1:0]              min_q;
	logic [BW-1:0]              max_q;
	logic [BW-1:0]              first_q;
	logic [BW-1:0]              middle_q;
	logic [LB-1:0]              seen_q;

	// frame snapshot taken with the closing byte
	logic [fss_pkg::HASH_W-1:0] hash_snap_q;
	logic [fss_pkg::SUM_W-1:0]  sum_snap_q;
	logic [BW-1:0]              min_snap_q;
	logic [BW-1:0]              max_snap_q;
	logic [BW-1:0]              first_snap_q;
	logic [BW-1:0]              middle_snap_q;
	logic [BW-1:0]              last_snap_q;
	logic [LB-1:0]              count_snap_q;

	// output register
	logic [fss_pkg::HASH_W-1:0] hash_out_q;
	logic [fss_pkg::SUM_W-1:0]  sum_out_q;
	logic [BW-1:0]              min_out_q;
	logic [BW-1:0]              max_out_q;
	logic [BW-1:0]              first_out_q;
	logic [BW-1:0]              middle_out_q;
	logic [BW-1:0]              last_out_q;
	logic [fss_pkg::MEAN_W-1:0] mean_out_q;

	logic [LB-1:0]              len_masked;
	logic [LB-1:0]              len_act;
	logic [LB-1:0]              mid_idx;
	logic [LB:0]                count;
	logic                       last_byte;
	logic [fss_pkg::HASH_W-1:0] hash_x;
	logic [fss_pkg::HASH_W-1:0] hash_prod;
	logic [fss_pkg::HASH_W-1:0] hash_n;
	logic [fss_pkg::SUM_W-1:0]  sum_n;
	logic [BW-1:0]              min_n;
	logic [BW-1:0]              max_n;
	logic [BW-1:0]              first_n;
	logic [BW-1:0]              middle_n;
	logic [fss_pkg::DVD_W-1:0]  dividend;
	logic [fss_pkg::DVD_W-1:0]  quotient;
	logic                       div_busy;
	logic                       div_done;

	// active length: low LENGTH_BITS of the register, zero read as one
	always_comb begin
		len_masked = LB'(frame_length_q);
		len_act    = (len_masked == '0) ? LB'(1) : len_masked;
		mid_idx    = len_act >> 1;
		count      = {1'b0, seen_q} + (LB+1)'(1);
		last_byte  = (count >= {1'b0, len_act});
	end

	// next values of the running statistics for the byte on the input
	always_comb begin
		hash_x    = hash_q ^ fss_pkg::HASH_W'(pixel_byte);
		hash_prod = hash_x * fss_pkg::FNV_PRIME;
		hash_n    = hash_prod;
		sum_n     = sum_q + fss_pkg::SUM_W'(pixel_byte);
		min_n     = (pixel_byte < min_q) ? pixel_byte : min_q;
		max_n     = (pixel_byte > max_q) ? pixel_byte : max_q;
		first_n   = (seen_q == '0) ? pixel_byte : first_q;
		middle_n  = (seen_q == mid_idx) ? pixel_byte : middle_q;
	end

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= fss_pkg::FRAME_LENGTH_RST;
		end else if (cfg_we) begin
			frame_length_q <= cfg_wdata;
		end
	end

	// running statistics; cleared when the frame closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q   <= fss_pkg::FNV_BASIS;
			sum_q    <= '0;
			min_q    <= fss_pkg::BYTE_TOP;
			max_q    <= '0;
			first_q  <= '0;
			middle_q <= '0;
			seen_q   <= '0;
		end else if (cmd.take) begin
			if (last_byte) begin
				hash_q   <= fss_pkg::FNV_BASIS;
				sum_q    <= '0;
				min_q    <= fss_pkg::BYTE_TOP;
				max_q    <= '0;
				first_q  <= '0;
				middle_q <= '0;
				seen_q   <= '0;
			end else begin
				hash_q   <= hash_n;
				sum_q    <= sum_n;
				min_q    <= min_n;
				max_q    <= max_n;
				first_q  <= first_n;
				middle_q <= middle_n;
				seen_q   <= count[LB-1:0];
			end
		end
	end

	// snapshot of the closed frame
	always_ff @(posedge clk) begin
		if (cmd.take && last_byte) begin
			hash_snap_q   <= hash_n;
			sum_snap_q    <= sum_n;
			min_snap_q    <= min_n;
			max_snap_q    <= max_n;
			first_snap_q  <= first_n;
			middle_snap_q <= middle_n;
			last_snap_q   <= pixel_byte;
			count_snap_q  <= count[LB-1:0];
		end
	end

	// mean: sum * 1000 divided by the byte count
	assign dividend = fss_pkg::DVD_W'(sum_snap_q) * fss_pkg::DVD_W'(fss_pkg::MILLI);

	fss_div #(
		.DIVISOR_W (LB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (count_snap_q),
		.quotient (quotient),
		.busy     (div_busy),
		.done     (div_done)
	);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hash_out_q   <= hash_snap_q;
			sum_out_q    <= sum_snap_q;
			min_out_q    <= min_snap_q;
			max_out_q    <= max_snap_q;
			first_out_q  <= first_snap_q;
			middle_out_q <= middle_snap_q;
			last_out_q   <= last_snap_q;
			mean_out_q   <= quotient[fss_pkg::MEAN_W-1:0];
		end
	end

	always_comb begin
		st.last_byte   = last_byte;
		st.frame_empty = (seen_q == '0);
		st.div_busy    = div_busy;
		st.div_done    = div_done;
	end

	assign frame_hash      = hash_out_q;
	assign byte_total      = sum_out_q;
	assign min_byte        = min_out_q;
	assign max_byte        = max_out_q;
	assign head_byte       = first_out_q;
	assign center_byte     = middle_out_q;
	assign tail_byte       = last_out_q;
	assign avg_thousandths = mean_out_q;

endmodule

### src/fss_ctrl.sv
// fss_ctrl: controller for byte intake, mean division and result hand-off.
// Depends on fss_pkg for the state type and the command and status structs.
module fss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  fss_pkg::fss_stat_t  st,
	output fss_pkg::fss_cmd_t   cmd
);

	fss_pkg::fss_state_t state_q, state_n;
	logic out_valid_q;
	logic slot_free;

	// state register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fss_pkg::ST_ACCUM;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register can take a result when empty or emptied this cycle
	assign slot_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_n       = state_q;
		in_ready      = 1'b0;
		cmd.take      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			fss_pkg::ST_ACCUM: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && st.last_byte) begin
					state_n = fss_pkg::ST_LAUNCH;
				end
			end
			fss_pkg::ST_LAUNCH: begin
				cmd.div_start = 1'b1;
				state_n       = fss_pkg::ST_DIVIDE;
			end
			fss_pkg::ST_DIVIDE: begin
				if (st.div_done) begin
					if (slot_free) begin
						cmd.load_out = 1'b1;
						state_n      = fss_pkg::ST_ACCUM;
					end else begin
						state_n = fss_pkg::ST_HOLD;
					end
				end
			end
			fss_pkg::ST_HOLD: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_n      = fss_pkg::ST_ACCUM;
				end
			end
			default: begin
				state_n = fss_pkg::ST_ACCUM;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### src/frame_signature_stats_top.sv
// frame_signature_stats_top: top level of the frame signature statistics block.
// Depends on fss_pkg, fss_if, fss_ctrl and fss_dp (with fss_div inside).

// Takes frame bytes on in_ch and delivers one result per frame on out_ch: the
// FNV-1a 32-bit hash, wrapping byte sum, minimum, maximum, first, middle
// (index length/2) and last byte, and the mean in thousandths. The user is to
// write the frame length through cfg_we/cfg_wdata (24 bits, low LENGTH_BITS
// used, zero read as one, reset value 1) only while the block is idle; the block
// does not enforce this, and a write does not restart the frame. Bytes are taken
// one per cycle; after the closing byte the input is held off while a radix-2
// divider computes the mean one quotient bit per cycle over the 42-bit product
// sum*1000. The result sits in an output register, so the next frame's bytes are
// taken while it waits; the input stalls further only if a second result is
// ready before the first one has been transferred.
module frame_signature_stats_top #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fss_pkg::CFG_W-1:0]   cfg_wdata,
	fss_in_if.sink                      in_ch,
	fss_out_if.source                   out_ch
);

	fss_pkg::fss_cmd_t  cmd;
	fss_pkg::fss_stat_t st;

	fss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	fss_dp #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.cmd             (cmd),
		.st              (st),
		.pixel_byte      (in_ch.pixel_byte),
		.frame_hash      (out_ch.frame_hash),
		.byte_total      (out_ch.byte_total),
		.min_byte        (out_ch.min_byte),
		.max_byte        (out_ch.max_byte),
		.head_byte       (out_ch.head_byte),
		.center_byte     (out_ch.center_byte),
		.tail_byte       (out_ch.tail_byte),
		.avg_thousandths (out_ch.avg_thousandths)
	);

	// a result never overwrites one that has not been transferred
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_ch.valid || out_ch.ready))
		else $error("result loaded over a pending output");

	// the closing byte leaves the running state empty for the next frame
	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && st.last_byte) |=> st.frame_empty)
		else $error("running state not cleared after frame close");

	// no byte is taken while the mean divider is working
	a_no_take_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !st.div_busy)
		else $error("input ready while divider busy");

	// a divider result only arrives once the divider has stopped and no byte is being taken
	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> !st.div_busy && !cmd.take)
		else $error("divider done outside of the divide phase");

endmodule

### bench/tb_frame_signature_stats_top.sv
// tb_frame_signature_stats_top: self-checking bench for frame_signature_stats_top.
// Streams frame bytes through the valid/ready channels and rewrites the frame length.
// Compares every frame result against a cycle-free model. Depends on fss_pkg and fss_if.
module tb_frame_signature_stats_top;

	localparam int unsigned  SETTLE_CYCLES  = 64;    // covers the mean divide
	localparam int unsigned  WATCHDOG_LIMIT = 3000;
	localparam int unsigned  RANDOM_BYTES   = 1850;
	localparam logic [31:0]  HASH_SEED      = 32'd2166136261;
	localparam logic [31:0]  HASH_MULT      = 32'd16777619;
	localparam logic [63:0]  MILLI_SCALE    = 64'd1000;
	localparam logic [fss_pkg::CFG_W-1:0] LEN_MAX = {fss_pkg::CFG_W{1'b1}};

	typedef struct packed {
		logic [fss_pkg::HASH_W-1:0] frame_hash;
		logic [fss_pkg::SUM_W-1:0]  byte_total;
		logic [fss_pkg::BYTE_W-1:0] min_byte;
		logic [fss_pkg::BYTE_W-1:0] max_byte;
		logic [fss_pkg::BYTE_W-1:0] head_byte;
		logic [fss_pkg::BYTE_W-1:0] center_byte;
		logic [fss_pkg::BYTE_W-1:0] tail_byte;
		logic [fss_pkg::MEAN_W-1:0] avg_thousandths;
	} signature_t;

	// Running frame statistics plus the queue of frame signatures still owed by the block
	class signature_board;
		logic [fss_pkg::CFG_W-1:0]  frame_len;
		logic [fss_pkg::HASH_W-1:0] run_hash;
		logic [fss_pkg::SUM_W-1:0]  run_sum;
		logic [fss_pkg::BYTE_W-1:0] run_min;
		logic [fss_pkg::BYTE_W-1:0] run_max;
		logic [fss_pkg::BYTE_W-1:0] first_b;
		logic [fss_pkg::BYTE_W-1:0] middle_b;
		logic [fss_pkg::CFG_W-1:0]  seen;
		signature_t                 pending_signatures[$];
		int unsigned                errors;
		int unsigned                checked;

		function new();
			frame_len = fss_pkg::FRAME_LENGTH_RST;
			errors = 0;
			checked = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			run_hash = HASH_SEED;
			run_sum = '0;
			run_min = 8'hFF;
			run_max = '0;
			first_b = '0;
			middle_b = '0;
			seen = '0;
		endfunction

		function void write_length(logic [fss_pkg::CFG_W-1:0] v);
			frame_len = v;
		endfunction

		// Fold one accepted byte into the frame; queue a signature when the frame closes
		function void take_byte(logic [fss_pkg::BYTE_W-1:0] b);
			logic [fss_pkg::CFG_W-1:0] len;
			logic [fss_pkg::CFG_W:0]   count;
			logic [63:0]               mean;
			signature_t                s;
			len = (frame_len == '0) ? fss_pkg::CFG_W'(1) : frame_len;
			if (seen == '0)
				first_b = b;
			if (seen == (len >> 1))
				middle_b = b;
			run_hash = (run_hash ^ {24'd0, b}) * HASH_MULT;
			run_sum = run_sum + {24'd0, b};
			if (b < run_min)
				run_min = b;
			if (b > run_max)
				run_max = b;
			count = {1'b0, seen} + 1'b1;
			if (count < {1'b0, len}) begin
				seen = count[fss_pkg::CFG_W-1:0];
				return;
			end
			// closing byte: divisor is the number of bytes actually taken in
			mean = ({32'd0, run_sum} * MILLI_SCALE) / {39'd0, count};
			s.frame_hash = run_hash;
			s.byte_total = run_sum;
			s.min_byte = run_min;
			s.max_byte = run_max;
			s.head_byte = first_b;
			s.center_byte = middle_b;
			s.tail_byte = b;
			s.avg_thousandths = mean[fss_pkg::MEAN_W-1:0];
			pending_signatures.push_back(s);
			clear_frame();
		endfunction

		function void compare_field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
			end
		endfunction

		function void check_signature(signature_t got);
			signature_t want;
			if (pending_signatures.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual hash %h", $time,
					got.frame_hash);
				return;
			end
			want = pending_signatures.pop_front();
			checked++;
			compare_field("frame_hash", want.frame_hash, got.frame_hash);
			compare_field("byte_total", want.byte_total, got.byte_total);
			compare_field("min_byte", 32'(want.min_byte), 32'(got.min_byte));
			compare_field("max_byte", 32'(want.max_byte), 32'(got.max_byte));
			compare_field("head_byte", 32'(want.head_byte), 32'(got.head_byte));
			compare_field("center_byte", 32'(want.center_byte), 32'(got.center_byte));
			compare_field("tail_byte", 32'(want.tail_byte), 32'(got.tail_byte));
			compare_field("avg_thousandths", 32'(want.avg_thousandths),
				32'(got.avg_thousandths));
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [fss_pkg::CFG_W-1:0]  cfg_wdata;
	fss_in_if                   in_ch();
	fss_out_if                  out_ch();

	signature_board    sb = new();
	int unsigned       bytes_sent;
	int unsigned       length_writes;
	int unsigned       idle_cycles;
	bit                no_gaps;

	frame_signature_stats_top #(.LENGTH_BITS(24)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side back-pressure
	always @(posedge clk) begin
		out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 10);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			sb.check_signature('{out_ch.frame_hash, out_ch.byte_total, out_ch.min_byte,
				out_ch.max_byte, out_ch.head_byte, out_ch.center_byte,
				out_ch.tail_byte, out_ch.avg_thousandths});
		end
	end

	// watchdog: no transfer and no register write for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("frame_signature_stats_top verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one byte transfer, with an occasional gap before it
	task automatic send_byte(input logic [fss_pkg::BYTE_W-1:0] b);
		no_gaps = (bytes_sent >= 700 && bytes_sent < 1000);
		if (!no_gaps && $urandom_range(0, 99) < 10) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_byte <= b;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	// hold off the input until every owed result has been transferred, then let the block settle
	task automatic drain_and_settle();
		in_ch.valid <= 1'b0;
		while (sb.pending_signatures.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// frame length write, only with the block idle
	task automatic set_length(input logic [fss_pkg::CFG_W-1:0] v);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_length(v);
		length_writes++;
	endtask

	initial begin
		int unsigned                random_target;
		int unsigned                roll;
		int unsigned                eff_len;
		int unsigned                n_bytes;
		int unsigned                mode;
		logic [fss_pkg::CFG_W-1:0]  new_len;
		logic [fss_pkg::BYTE_W-1:0] cval;
		logic [fss_pkg::BYTE_W-1:0] b;

		bytes_sent = 0;
		length_writes = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.pixel_byte <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset length of one, byte extremes
		send_byte(8'h00);
		send_byte(8'hFF);
		// zero length behaves as one
		set_length('0);
		send_byte(8'hA5);
		set_length(fss_pkg::CFG_W'(2));
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		set_length(fss_pkg::CFG_W'(5));
		send_byte(8'd7);
		send_byte(8'd200);
		send_byte(8'd128);
		send_byte(8'd1);
		send_byte(8'd254);
		// longest length, then shortened to the number of bytes already taken: closes at once,
		// middle index never reached
		set_length(LEN_MAX);
		send_byte(8'd10);
		send_byte(8'd20);
		send_byte(8'd30);
		set_length(fss_pkg::CFG_W'(3));
		send_byte(8'd40);
		// length raised mid-frame: frame keeps going
		set_length(fss_pkg::CFG_W'(4));
		send_byte(8'd90);
		send_byte(8'd91);
		set_length(fss_pkg::CFG_W'(8));
		repeat (6) send_byte(8'($urandom_range(0, 255)));

		// random phases: new length, a few frames, sometimes a partial frame left open
		random_target = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < random_target) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				new_len = '0;
			else if (roll < 7)
				new_len = LEN_MAX - fss_pkg::CFG_W'($urandom_range(0, 3));
			else if (roll < 30)
				new_len = fss_pkg::CFG_W'($urandom_range(1, 4));
			else if (roll < 85)
				new_len = fss_pkg::CFG_W'($urandom_range(5, 40));
			else
				new_len = fss_pkg::CFG_W'($urandom_range(41, 300));
			set_length(new_len);
			eff_len = (new_len == '0) ? 1 : int'(new_len);
			if (eff_len > 300) begin
				n_bytes = $urandom_range(1, 12);
			end else begin
				n_bytes = eff_len * $urandom_range(1, 4);
				if ($urandom_range(0, 99) < 15)
					n_bytes += $urandom_range(1, eff_len);
			end
			mode = 0;
			cval = '0;
			for (int unsigned k = 0; k < n_bytes && bytes_sent < random_target; k++) begin
				if (eff_len > 300 || (k % eff_len) == 0) begin
					mode = $urandom_range(0, 5);
					cval = 8'($urandom_range(0, 255));
				end
				case (mode)
					2: begin
						b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
					end
					3: begin
						b = cval;
					end
					4: begin
						b = 8'($urandom_range(0, 15));
					end
					5: begin
						b = 8'($urandom_range(240, 255));
					end
					default: begin
						b = 8'($urandom_range(0, 255));
					end
				endcase
				send_byte(b);
			end
		end

		drain_and_settle();
		$display("Streamed %0d bytes over %0d frame length writes; %0d frame results checked.",
			bytes_sent, length_writes, sb.checked);
		if (sb.errors == 0 && sb.pending_signatures.size() == 0) begin
			$display("frame_signature_stats_top verification clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.errors,
				sb.pending_signatures.size());
			$display("frame_signature_stats_top verification failed");
		end
		$finish;
	end

endmodule
